/* design/nitrogen_sensor_scaling_assert.svh */
// Assertion macros used by the nitrogen sensor scaling checker.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef NITROGEN_SENSOR_SCALING_ASSERT_SVH
`define NITROGEN_SENSOR_SCALING_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define NSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion on the result payload, checked whenever a result is offered.
`define NSS_ASSERT_RESULT(lbl, expr, msg) \
	`NSS_ASSERT(lbl, out_valid |-> (expr), msg)

`endif

/* design/nss_pkg.sv */
// Package for the nitrogen sensor scaling block: widths, register codes,
// scaling constants and the types shared by the lane, pressure and merge modules.
`timescale 1ns / 1ps

package nss_pkg;

	// Channel count. Five channels are carried on the ports; the active count
	// is limited to 1..PHYS_CHANNELS.
	localparam int PHYS_CHANNELS = 5;
	localparam int NUM_CHANNELS  = 5;
	localparam int NUM_ACTIVE    = (NUM_CHANNELS < 1) ? 1 :
		((NUM_CHANNELS > PHYS_CHANNELS) ? PHYS_CHANNELS : NUM_CHANNELS);

	// Field widths.
	localparam int RAW_W      = 16;
	localparam int CONC_W     = 10;
	localparam int TANK_W     = 14;
	localparam int MAIN_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	typedef logic [RAW_W-1:0]         raw_t;
	typedef logic [CONC_W-1:0]        conc_t;
	typedef logic signed [TANK_W-1:0] tank_t;
	typedef logic signed [MAIN_W-1:0] main_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	// Raw value minus its offset, signed, one bit wider than the raw field.
	localparam int DIFF_W = RAW_W + 1;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Register indexes.
	localparam cfg_idx_t CFG_DEVICE_MODEL      = cfg_idx_t'(0);
	localparam int       CFG_CHANNEL_TYPE_BASE = 1;

	// Register codes.
	localparam cfg_data_t CT_INVERTED  = cfg_data_t'(1);
	localparam cfg_data_t CT_DIRECT    = cfg_data_t'(2);
	localparam cfg_data_t DM_MAIN_ONLY = cfg_data_t'(3);

	localparam int    RAW_OFFSET   = 10000;
	localparam diff_t RAW_OFFSET_D = diff_t'(RAW_OFFSET);
	localparam int    CONC_FULL    = 1000;

	// Shared reciprocal of five: floor(y / 5) = (y * RECIP5) >> RECIP5_SHIFT,
	// exact for y below 2**14.
	localparam int RECIP5_SHIFT = 16;
	localparam int RECIP5_W     = 17;
	localparam logic [RECIP5_W-1:0] RECIP5 =
		RECIP5_W'(((64'd1 << RECIP5_SHIFT) + 64'd4) / 64'd5);

	// Inverted type: d * 52 / 10000 = d * 13 / 2500. The factor 13 is folded
	// into the reciprocal of 2500 so that a single constant product remains.
	localparam int INV_NUM   = 13;
	localparam int INV_DEN   = 2500;
	localparam int INV_SHIFT = 32;
	localparam longint unsigned INV_MUL_VAL = longint'(INV_NUM) *
		(((64'd1 << INV_SHIFT) + longint'(INV_DEN) - 64'd1) / longint'(INV_DEN));
	localparam int INV_MUL_W  = $clog2(INV_MUL_VAL + 1);
	localparam int INV_PROD_W = RAW_W + INV_MUL_W;
	localparam int INV_T_W    = INV_PROD_W - INV_SHIFT;
	localparam logic [INV_MUL_W-1:0] INV_MUL = INV_MUL_W'(INV_MUL_VAL);
	localparam int INV_CLAMP  = 500;

	// Direct type: d / 40 = (d >> 3) / 5.
	localparam int DIRECT_DIV   = 40;
	localparam int DIRECT_SHIFT = 3;
	localparam int DIR_Y_W      = RAW_W - DIRECT_SHIFT;
	localparam int DIR_PROD_W   = DIR_Y_W + RECIP5_W;

	// Tank pressure: (raw - 30000) / 4, clamped to +-5000.
	localparam int TANK_DIFF_W = RAW_W + 2;
	typedef logic signed [TANK_DIFF_W-1:0] tank_diff_t;
	localparam tank_diff_t TANK_BIAS  = tank_diff_t'(RAW_OFFSET + 20000);
	localparam int         TANK_SHIFT = 2;
	localparam tank_diff_t TANK_ROUND = tank_diff_t'((1 << TANK_SHIFT) - 1);
	localparam tank_diff_t TANK_MAX   = tank_diff_t'(5000);
	localparam tank_diff_t TANK_MIN   = -tank_diff_t'(5000);

	// Main pressure: d / 320 = (|d| >> 6) / 5 with the sign restored.
	localparam int MAIN_SHIFT  = 6;
	localparam int MAIN_Y_W    = RAW_W - MAIN_SHIFT;
	localparam int MAIN_PROD_W = MAIN_Y_W + RECIP5_W;

	// Average: sum / NUM_ACTIVE through a reciprocal, exact for sums of up to
	// five ten-bit values.
	localparam int SUM_W      = $clog2(PHYS_CHANNELS * ((1 << CONC_W) - 1) + 1);
	localparam int AVG_SHIFT  = 16;
	localparam int AVG_MUL_W  = AVG_SHIFT + 1;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(
		((64'd1 << AVG_SHIFT) + longint'(NUM_ACTIVE) - 64'd1) / longint'(NUM_ACTIVE));
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

	// Which stored values a transfer updates.
	typedef struct packed {
		logic load_conc;
		logic load_tank;
		logic load_main;
	} upd_ctrl_t;

endpackage

/* design/nss_lane.sv */
// One concentration lane: scales the raw value by the channel type and holds
// the stored concentration. Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  nss_pkg::cfg_data_t ctype,
	input  nss_pkg::raw_t     raw,
	output nss_pkg::conc_t    conc
);

	nss_pkg::diff_t                       d;
	logic [nss_pkg::RAW_W-1:0]            d_low;
	logic [nss_pkg::INV_PROD_W-1:0]       inv_prod;
	logic [nss_pkg::INV_T_W-1:0]          inv_t;
	logic [nss_pkg::INV_T_W-1:0]          inv_clamped;
	nss_pkg::conc_t                       inv_conc;
	logic [nss_pkg::DIR_PROD_W-1:0]       dir_prod;
	logic [nss_pkg::DIR_PROD_W-nss_pkg::RECIP5_SHIFT-1:0] dir_q;
	nss_pkg::conc_t                       dir_conc;
	nss_pkg::conc_t                       conc_nxt;
	nss_pkg::conc_t                       conc_q;

	assign d     = nss_pkg::diff_t'({1'b0, raw}) - nss_pkg::RAW_OFFSET_D;
	assign d_low = d[nss_pkg::RAW_W-1:0];

	// Inverted type: 1000 minus the scaled offset value, the scaled value held
	// to 0..500.
	assign inv_prod = nss_pkg::INV_PROD_W'(d_low) * nss_pkg::INV_PROD_W'(nss_pkg::INV_MUL);
	assign inv_t    = inv_prod[nss_pkg::INV_PROD_W-1:nss_pkg::INV_SHIFT];

	always_comb begin
		if (d <= nss_pkg::diff_t'(0)) begin
			inv_clamped = '0;
		end else if (inv_t > nss_pkg::INV_CLAMP) begin
			inv_clamped = nss_pkg::INV_T_W'(nss_pkg::INV_CLAMP);
		end else begin
			inv_clamped = inv_t;
		end
		inv_conc = nss_pkg::conc_t'(nss_pkg::CONC_FULL - int'(inv_clamped));
	end

	// Direct type: the offset value over 40. A quotient below zero, or one
	// above full scale, reads as full scale; small negatives truncate to zero.
	assign dir_prod = nss_pkg::DIR_PROD_W'(d_low[nss_pkg::RAW_W-1:nss_pkg::DIRECT_SHIFT]) *
		nss_pkg::DIR_PROD_W'(nss_pkg::RECIP5);
	assign dir_q = dir_prod[nss_pkg::DIR_PROD_W-1:nss_pkg::RECIP5_SHIFT];

	always_comb begin
		if (d <= -nss_pkg::diff_t'(nss_pkg::DIRECT_DIV)) begin
			dir_conc = nss_pkg::conc_t'(nss_pkg::CONC_FULL);
		end else if (d < nss_pkg::diff_t'(0)) begin
			dir_conc = '0;
		end else if (dir_q > nss_pkg::CONC_FULL) begin
			dir_conc = nss_pkg::conc_t'(nss_pkg::CONC_FULL);
		end else begin
			dir_conc = nss_pkg::conc_t'(dir_q);
		end
	end

	always_comb begin
		case (ctype)
			nss_pkg::CT_INVERTED: conc_nxt = inv_conc;
			nss_pkg::CT_DIRECT:   conc_nxt = dir_conc;
			default:              conc_nxt = conc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conc_q <= '0;
		end else if (load) begin
			conc_q <= conc_nxt;
		end
	end

	assign conc = conc_q;

endmodule

/* design/nss_press.sv */
// Tank and main pipe pressure scaling with their stored values.
// Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_press (
	input  logic               clk,
	input  logic               arst_n,
	input  nss_pkg::upd_ctrl_t upd,
	input  nss_pkg::raw_t      raw_tank,
	input  nss_pkg::raw_t      raw_main,
	output nss_pkg::tank_t     tank,
	output nss_pkg::main_t     main
);

	nss_pkg::tank_diff_t               tv;
	nss_pkg::tank_diff_t               tq;
	nss_pkg::tank_t                    tank_nxt;
	nss_pkg::tank_t                    tank_q;
	nss_pkg::diff_t                    md;
	logic                              m_neg;
	logic [nss_pkg::RAW_W-1:0]         m_mag;
	logic [nss_pkg::MAIN_PROD_W-1:0]   m_prod;
	nss_pkg::main_t                    m_quot;
	nss_pkg::main_t                    main_nxt;
	nss_pkg::main_t                    main_q;

	// Quotient by four truncated toward zero, then held to +-5000.
	assign tv = nss_pkg::tank_diff_t'({2'b00, raw_tank}) - nss_pkg::TANK_BIAS;

	always_comb begin
		if (tv < nss_pkg::tank_diff_t'(0)) begin
			tq = (tv + nss_pkg::TANK_ROUND) >>> nss_pkg::TANK_SHIFT;
		end else begin
			tq = tv >>> nss_pkg::TANK_SHIFT;
		end
		if (tq > nss_pkg::TANK_MAX) begin
			tank_nxt = nss_pkg::tank_t'(nss_pkg::TANK_MAX);
		end else if (tq < nss_pkg::TANK_MIN) begin
			tank_nxt = nss_pkg::tank_t'(nss_pkg::TANK_MIN);
		end else begin
			tank_nxt = nss_pkg::tank_t'(tq);
		end
	end

	// The main pressure quotient is formed on the magnitude and the sign put
	// back, which gives truncation toward zero.
	assign md    = nss_pkg::diff_t'({1'b0, raw_main}) - nss_pkg::RAW_OFFSET_D;
	assign m_neg = md < nss_pkg::diff_t'(0);
	assign m_mag = m_neg ? nss_pkg::RAW_W'(-md) : nss_pkg::RAW_W'(md);
	assign m_prod = nss_pkg::MAIN_PROD_W'(m_mag[nss_pkg::RAW_W-1:nss_pkg::MAIN_SHIFT]) *
		nss_pkg::MAIN_PROD_W'(nss_pkg::RECIP5);
	assign m_quot = nss_pkg::main_t'(m_prod[nss_pkg::MAIN_PROD_W-1:nss_pkg::RECIP5_SHIFT]);
	assign main_nxt = m_neg ? -m_quot : m_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tank_q <= '0;
			main_q <= '0;
		end else begin
			if (upd.load_tank) begin
				tank_q <= tank_nxt;
			end
			if (upd.load_main) begin
				main_q <= main_nxt;
			end
		end
	end

	assign tank = tank_q;
	assign main = main_q;

endmodule

/* design/nss_merge.sv */
// Merge stage: average and minimum over the active lanes, and the result
// register that holds a finished result until it is taken. Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_merge (
	input  logic           clk,
	input  logic           capture,
	input  nss_pkg::conc_t conc [nss_pkg::PHYS_CHANNELS],
	input  nss_pkg::tank_t tank,
	input  nss_pkg::main_t main,
	output nss_pkg::conc_t out_conc [nss_pkg::PHYS_CHANNELS],
	output nss_pkg::conc_t out_average,
	output nss_pkg::conc_t out_minimum,
	output nss_pkg::tank_t out_tank,
	output nss_pkg::main_t out_main
);

	logic [nss_pkg::SUM_W-1:0]      sum;
	nss_pkg::conc_t                 mn;
	logic [nss_pkg::AVG_PROD_W-1:0] avg_prod;
	nss_pkg::conc_t                 avg;
	nss_pkg::conc_t                 conc_q [nss_pkg::PHYS_CHANNELS];
	nss_pkg::conc_t                 average_q;
	nss_pkg::conc_t                 minimum_q;
	nss_pkg::tank_t                 tank_q;
	nss_pkg::main_t                 main_q;

	always_comb begin
		sum = '0;
		mn  = conc[0];
		for (int i = 0; i < nss_pkg::NUM_ACTIVE; i++) begin
			sum = sum + nss_pkg::SUM_W'(conc[i]);
			if (conc[i] < mn) begin
				mn = conc[i];
			end
		end
	end

	assign avg_prod = nss_pkg::AVG_PROD_W'(sum) * nss_pkg::AVG_PROD_W'(nss_pkg::AVG_MUL);
	assign avg      = nss_pkg::conc_t'(avg_prod >> nss_pkg::AVG_SHIFT);

	always_ff @(posedge clk) begin
		if (capture) begin
			conc_q    <= conc;
			average_q <= avg;
			minimum_q <= mn;
			tank_q    <= tank;
			main_q    <= main;
		end
	end

	assign out_conc    = conc_q;
	assign out_average = average_q;
	assign out_minimum = minimum_q;
	assign out_tank    = tank_q;
	assign out_main    = main_q;

endmodule

/* design/nitrogen_sensor_scaling.sv */
// Nitrogen sensor scaling: an input transfer updates the stored values, which stage
// one marks; the merge stage with its averaging multiplier then loads them into the
// result register. One sample is taken in every cycle while the result register is
// free or is being emptied. arst_n low clears the stored values, the configuration
// registers and both valid flags; the result register itself has no reset.
`timescale 1ns / 1ps

// Each polled sample set is scaled by five concentration lanes working side by
// side, one per channel, while the pressure unit rescales the tank or the main
// pipe pressure. The lanes and the pressure unit hold the stored values, so a
// sample updates them at its input transfer. When stage one then advances, the merge
// stage forms the average and the minimum over the active lanes and loads the
// result register together with a copy of every stored value.
//
// Stage one is marked only by valid_s1: its payload is the stored state itself.
// That is why a new sample is refused while stage one is full and cannot move
// on: taking it would change the state before its result has been captured.
// While the result register is free or is being emptied, samples flow at one
// per cycle even with a result waiting at the output.
//
// Configuration writes are registered. A write to an index beyond the
// register list is ignored.

module nitrogen_sensor_scaling (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  nss_pkg::cfg_idx_t   cfg_index,
	input  nss_pkg::cfg_data_t  cfg_data,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic                update_enable,
	input  nss_pkg::raw_t       raw_ch0,
	input  nss_pkg::raw_t       raw_ch1,
	input  nss_pkg::raw_t       raw_ch2,
	input  nss_pkg::raw_t       raw_ch3,
	input  nss_pkg::raw_t       raw_ch4,
	input  nss_pkg::raw_t       raw_tank_pressure,
	input  nss_pkg::raw_t       raw_main_pressure,

	output logic                out_valid,
	input  logic                out_ready,
	output nss_pkg::conc_t      conc_0,
	output nss_pkg::conc_t      conc_1,
	output nss_pkg::conc_t      conc_2,
	output nss_pkg::conc_t      conc_3,
	output nss_pkg::conc_t      conc_4,
	output nss_pkg::conc_t      conc_average,
	output nss_pkg::conc_t      conc_minimum,
	output nss_pkg::tank_t      tank_pressure,
	output nss_pkg::main_t      main_pressure
);

	nss_pkg::cfg_data_t  device_model_q;
	nss_pkg::cfg_data_t  ctype_q [nss_pkg::PHYS_CHANNELS];
	nss_pkg::raw_t       raw_ch [nss_pkg::PHYS_CHANNELS];
	nss_pkg::conc_t      conc_store [nss_pkg::PHYS_CHANNELS];
	nss_pkg::conc_t      out_conc [nss_pkg::PHYS_CHANNELS];
	nss_pkg::tank_t      tank_store;
	nss_pkg::main_t      main_store;
	nss_pkg::upd_ctrl_t  upd;
	logic                in_xfer;
	logic                advance;
	logic                valid_s1;
	logic                out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_model_q <= '0;
			for (int i = 0; i < nss_pkg::PHYS_CHANNELS; i++) begin
				ctype_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == nss_pkg::CFG_DEVICE_MODEL) begin
				device_model_q <= cfg_data;
			end
			for (int i = 0; i < nss_pkg::PHYS_CHANNELS; i++) begin
				if (cfg_index == nss_pkg::cfg_idx_t'(nss_pkg::CFG_CHANNEL_TYPE_BASE + i)) begin
					ctype_q[i] <= cfg_data;
				end
			end
		end
	end

	// Handshake. The result register can take stage one when it is empty or
	// its result is taken in this cycle.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A sample with updates enabled rescales either the concentrations and the
	// tank pressure, or, in a nitrogen room installation, the main pressure.
	always_comb begin
		upd.load_conc = in_xfer && update_enable && (device_model_q != nss_pkg::DM_MAIN_ONLY);
		upd.load_tank = upd.load_conc;
		upd.load_main = in_xfer && update_enable && (device_model_q == nss_pkg::DM_MAIN_ONLY);
	end

	assign raw_ch[0] = raw_ch0;
	assign raw_ch[1] = raw_ch1;
	assign raw_ch[2] = raw_ch2;
	assign raw_ch[3] = raw_ch3;
	assign raw_ch[4] = raw_ch4;

	// Lanes at or above the active count are never updated and read as zero.
	for (genvar g = 0; g < nss_pkg::PHYS_CHANNELS; g++) begin : g_lane
		if (g < nss_pkg::NUM_ACTIVE) begin : g_active
			nss_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.load   (upd.load_conc),
				.ctype  (ctype_q[g]),
				.raw    (raw_ch[g]),
				.conc   (conc_store[g])
			);
		end else begin : g_idle
			assign conc_store[g] = '0;
		end
	end

	nss_press u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.raw_tank (raw_tank_pressure),
		.raw_main (raw_main_pressure),
		.tank     (tank_store),
		.main     (main_store)
	);

	nss_merge u_merge (
		.clk         (clk),
		.capture     (valid_s1 && advance),
		.conc        (conc_store),
		.tank        (tank_store),
		.main        (main_store),
		.out_conc    (out_conc),
		.out_average (conc_average),
		.out_minimum (conc_minimum),
		.out_tank    (tank_pressure),
		.out_main    (main_pressure)
	);

	assign conc_0 = out_conc[0];
	assign conc_1 = out_conc[1];
	assign conc_2 = out_conc[2];
	assign conc_3 = out_conc[3];
	assign conc_4 = out_conc[4];

endmodule

/* design/nss_checker.sv */
// Port-level checks for the nitrogen sensor scaling block and the bind that
// attaches them. Depends on nss_pkg and nitrogen_sensor_scaling_assert.svh.
`timescale 1ns / 1ps

`include "nitrogen_sensor_scaling_assert.svh"

module nss_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input nss_pkg::conc_t conc_0,
	input nss_pkg::conc_t conc_average,
	input nss_pkg::conc_t conc_minimum,
	input nss_pkg::tank_t tank_pressure
);

	logic avg_ok;
	logic tank_ok;

	assign avg_ok  = conc_average <= nss_pkg::conc_t'(nss_pkg::CONC_FULL);
	assign tank_ok = (tank_pressure <= nss_pkg::tank_t'(nss_pkg::TANK_MAX)) &&
		(tank_pressure >= nss_pkg::tank_t'(nss_pkg::TANK_MIN));

	// A stalled result stays offered.
	`NSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

	// Every input transfer puts a result on offer, through valid_s1 and then the output valid flag.
	`NSS_ASSERT(a_result_follows, in_valid && in_ready |-> ##2 out_valid, "missing result")

	// Channel zero is always active, so the minimum never exceeds it.
	`NSS_ASSERT_RESULT(a_min_le_ch0, conc_minimum <= conc_0, "minimum above channel zero")

	// The average of values within full scale stays within full scale.
	`NSS_ASSERT_RESULT(a_avg_range, avg_ok, "average out of range")

	// Tank pressure is held to plus or minus 5000.
	`NSS_ASSERT_RESULT(a_tank_range, tank_ok, "tank pressure out of range")

endmodule

bind nitrogen_sensor_scaling nss_checker u_nss_checker (.*);

/* bench/nitrogen_sensor_scaling_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for nitrogen_sensor_scaling: sends polled sample sets and register
// writes, predicts every result and compares it field by field. Needs nss_pkg and the RTL.

module nitrogen_sensor_scaling_tb;
	import nss_pkg::*;

	// Bench timing and run length.
	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int MAX_WAIT      = 9;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 105;
	localparam int CFG_SLOTS     = 1 << CFG_IDX_W;

	// Register codes that the package does not name. Models 0 to 2 all scale the same way.
	localparam cfg_data_t DM_PLAIN     = cfg_data_t'(0);
	localparam cfg_data_t DM_MID_PLAIN = cfg_data_t'(1);
	localparam cfg_data_t DM_TOP_PLAIN = cfg_data_t'(2);
	localparam cfg_data_t CT_HOLD      = cfg_data_t'(0);
	localparam cfg_data_t CT_HOLD_ALT  = cfg_data_t'(3);

	// Scaling figures of the sensors, in exact integer form.
	localparam int SCALE_INV_GAIN = 52;
	localparam int SCALE_INV_DIV  = 10000;
	localparam int SCALE_INV_CAP  = 500;
	localparam int SCALE_DIR_DIV  = 40;
	localparam int TANK_ZERO_D    = 20000;
	localparam int TANK_DIV       = 4;
	localparam int TANK_CAP       = 5000;
	localparam int PIPE_DIV       = 320;

	typedef logic [PHYS_CHANNELS-1:0][CFG_DATA_W-1:0] type_set_t;

	typedef struct packed {
		logic                      update;
		raw_t [PHYS_CHANNELS-1:0]  ch;
		raw_t                      tank;
		raw_t                      pipe;
	} sample_t;

	typedef struct packed {
		conc_t [PHYS_CHANNELS-1:0] conc;
		conc_t                     avg;
		conc_t                     lowest;
		tank_t                     tank;
		main_t                     pipe;
	} reading_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_ready;
	logic      update_enable;
	raw_t      raw_ch0;
	raw_t      raw_ch1;
	raw_t      raw_ch2;
	raw_t      raw_ch3;
	raw_t      raw_ch4;
	raw_t      raw_tank_pressure;
	raw_t      raw_main_pressure;
	logic      out_valid;
	logic      out_ready;
	conc_t     conc_0;
	conc_t     conc_1;
	conc_t     conc_2;
	conc_t     conc_3;
	conc_t     conc_4;
	conc_t     conc_average;
	conc_t     conc_minimum;
	tank_t     tank_pressure;
	main_t     main_pressure;

	// Shadow copy of the registers and the stored values, kept in step with the block.
	cfg_data_t                 model_shadow;
	type_set_t                 type_shadow;
	conc_t [PHYS_CHANNELS-1:0] conc_shadow;
	tank_t                     tank_shadow;
	main_t                     pipe_shadow;

	// Readings predicted for accepted samples, oldest first.
	reading_t expected_readings[$];

	// Upper bound of the random wait on each side; zero gives a stretch with no idling.
	int src_wait_max;
	int sink_wait_max;

	int cycle_count;
	int samples_sent;
	int results_checked;
	int mismatch_count;
	int settings_count;
	int drain_pauses;

	nitrogen_sensor_scaling dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.update_enable     (update_enable),
		.raw_ch0           (raw_ch0),
		.raw_ch1           (raw_ch1),
		.raw_ch2           (raw_ch2),
		.raw_ch3           (raw_ch3),
		.raw_ch4           (raw_ch4),
		.raw_tank_pressure (raw_tank_pressure),
		.raw_main_pressure (raw_main_pressure),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.conc_0            (conc_0),
		.conc_1            (conc_1),
		.conc_2            (conc_2),
		.conc_3            (conc_3),
		.conc_4            (conc_4),
		.conc_average      (conc_average),
		.conc_minimum      (conc_minimum),
		.tank_pressure     (tank_pressure),
		.main_pressure     (main_pressure)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// The run is cut off here if the block stops moving; the limit is many times the
	// slowest clean run, with every sample and every result waiting out the longest gap.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycle_count,
				expected_readings.size());
			$display("nitrogen_sensor_scaling_tb: done, errors");
			$finish;
		end
	end

	// Applies one sample set to the shadow state and returns the reading the block
	// must emit for it. Every sample gives exactly one reading.
	function automatic reading_t predict_reading(input sample_t s);
		reading_t r;
		int d;
		int t;
		int sum;
		if (s.update) begin
			if (model_shadow != DM_MAIN_ONLY) begin
				for (int i = 0; i < NUM_ACTIVE; i++) begin
					d = int'(s.ch[i]) - RAW_OFFSET;
					if (type_shadow[i] == CT_INVERTED) begin
						// Inverted sensor: full scale minus the clamped drop.
						t = d * SCALE_INV_GAIN / SCALE_INV_DIV;
						if (t < 0)
							t = 0;
						else if (t > SCALE_INV_CAP)
							t = SCALE_INV_CAP;
						conc_shadow[i] = conc_t'(CONC_FULL - t);
					end else if (type_shadow[i] == CT_DIRECT) begin
						// Direct sensor: a negative quotient reads as full scale too.
						t = d / SCALE_DIR_DIV;
						if (t < 0 || t > CONC_FULL)
							t = CONC_FULL;
						conc_shadow[i] = conc_t'(t);
					end
				end
				t = (int'(s.tank) - RAW_OFFSET - TANK_ZERO_D) / TANK_DIV;
				if (t < -TANK_CAP)
					t = -TANK_CAP;
				else if (t > TANK_CAP)
					t = TANK_CAP;
				tank_shadow = tank_t'(t);
			end else begin
				pipe_shadow = main_t'((int'(s.pipe) - RAW_OFFSET) / PIPE_DIV);
			end
		end
		sum = 0;
		r.lowest = conc_shadow[0];
		for (int i = 0; i < NUM_ACTIVE; i++) begin
			sum += int'(conc_shadow[i]);
			if (conc_shadow[i] < r.lowest)
				r.lowest = conc_shadow[i];
		end
		r.conc = conc_shadow;
		r.avg  = conc_t'(sum / NUM_ACTIVE);
		r.tank = tank_shadow;
		r.pipe = pipe_shadow;
		return r;
	endfunction

	function automatic void compare_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("mismatch on %s in result %0d: expected %0d, got %0d", what,
					results_checked, want, got);
		end
	endfunction

	// Result checker: every output transfer is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		reading_t got;
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			got.conc   = {conc_4, conc_3, conc_2, conc_1, conc_0};
			got.avg    = conc_average;
			got.lowest = conc_minimum;
			got.tank   = tank_pressure;
			got.pipe   = main_pressure;
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result transfer %0d arrived with no sample waiting for it",
						results_checked);
			end else begin
				want = expected_readings.pop_front();
				for (int i = 0; i < PHYS_CHANNELS; i++)
					compare_field($sformatf("conc_%0d", i), int'(want.conc[i]),
						int'(got.conc[i]));
				compare_field("conc_average", int'(want.avg), int'(got.avg));
				compare_field("conc_minimum", int'(want.lowest), int'(got.lowest));
				compare_field("tank_pressure", int'($signed(want.tank)),
					int'($signed(got.tank)));
				compare_field("main_pressure", int'($signed(want.pipe)),
					int'($signed(got.pipe)));
			end
			results_checked++;
		end
	end

	function automatic int draw_wait(input int limit);
		return $urandom_range(0, limit);
	endfunction

	// Result side: before each transfer the receiver stalls for a random number of cycles.
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(sink_wait_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Sends one sample set. Called at a falling edge and returns at one. With no gap
	// drawn, valid stays high from the previous transfer and only the payload moves.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = draw_wait(src_wait_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		update_enable     <= s.update;
		raw_ch0           <= s.ch[0];
		raw_ch1           <= s.ch[1];
		raw_ch2           <= s.ch[2];
		raw_ch3           <= s.ch[3];
		raw_ch4           <= s.ch[4];
		raw_tank_pressure <= s.tank;
		raw_main_pressure <= s.pipe;
		in_valid          <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_readings.push_back(predict_reading(s));
		samples_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted reading has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
	endtask

	// Writes every register index in turn, including the two unused ones, whose
	// writes carry random data and must be ignored. Only called while idle.
	task automatic program_regs(input cfg_data_t model, input type_set_t types);
		cfg_we <= 1'b1;
		for (int i = 0; i < CFG_SLOTS; i++) begin
			cfg_index <= cfg_idx_t'(i);
			if (cfg_idx_t'(i) == CFG_DEVICE_MODEL)
				cfg_data <= model;
			else if (i < CFG_CHANNEL_TYPE_BASE + PHYS_CHANNELS)
				cfg_data <= types[i - CFG_CHANNEL_TYPE_BASE];
			else
				cfg_data <= cfg_data_t'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		model_shadow = model;
		type_shadow  = types;
		settings_count++;
	endtask

	// Raw values lean toward the points where the scaling clamps or changes sign.
	function automatic raw_t pick_raw();
		raw_t edges [6] = '{raw_t'(9808), raw_t'(9960), raw_t'(10000), raw_t'(30000),
			raw_t'(50000), raw_t'(50040)};
		case ($urandom_range(0, 4))
			0, 1: return raw_t'($urandom);
			2: return raw_t'(int'(edges[$urandom_range(0, 5)]) + $urandom_range(0, 16) - 8);
			3: return raw_t'($urandom_range(9000, 11000));
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.update = ($urandom_range(0, 9) != 0);
		for (int i = 0; i < PHYS_CHANNELS; i++)
			s.ch[i] = pick_raw();
		s.tank = pick_raw();
		s.pipe = pick_raw();
		return s;
	endfunction

	// Right after reset all channel types hold, so only tank pressure may move.
	task automatic test_reset_defaults();
		sample_t s;
		s.update = 1'b1;
		s.ch     = '1;
		s.tank   = '1;
		s.pipe   = '0;
		send_sample(s);
		s.ch   = '0;
		s.tank = '0;
		s.pipe = '1;
		send_sample(s);
		s = random_sample();
		s.update = 1'b0;
		send_sample(s);
	endtask

	// Field extremes and clamp boundaries on both sensor types and on tank pressure.
	// Channels are staggered through the list so that average and minimum vary.
	task automatic test_scaling_extremes();
		raw_t conc_edges [10] = '{raw_t'(0), raw_t'(9807), raw_t'(9808), raw_t'(9960),
			raw_t'(9961), raw_t'(10000), raw_t'(10039), raw_t'(50039), raw_t'(50040),
			raw_t'(65535)};
		raw_t tank_edges [10] = '{raw_t'(0), raw_t'(10000), raw_t'(29999), raw_t'(30000),
			raw_t'(30003), raw_t'(50003), raw_t'(50004), raw_t'(50007), raw_t'(65535),
			raw_t'(29996)};
		sample_t s;
		drain_results();
		// Channel 4 is the leftmost entry of the type set.
		program_regs(DM_PLAIN, {CT_INVERTED, CT_DIRECT, CT_INVERTED, CT_DIRECT, CT_INVERTED});
		for (int k = 0; k < 10; k++) begin
			s.update = 1'b1;
			for (int i = 0; i < PHYS_CHANNELS; i++)
				s.ch[i] = conc_edges[(k + 3 * i) % 10];
			s.tank = tank_edges[k];
			s.pipe = raw_t'($urandom);
			send_sample(s);
		end
	endtask

	// Both hold codes must keep the concentrations stored by the previous test.
	task automatic test_hold_types();
		sample_t s;
		drain_results();
		program_regs(DM_MID_PLAIN, {CT_DIRECT, CT_HOLD, CT_HOLD_ALT, CT_HOLD, CT_HOLD_ALT});
		for (int k = 0; k < 4; k++) begin
			s = random_sample();
			s.update = (k != 3);
			send_sample(s);
		end
	endtask

	// With update disabled nothing may change, whatever the raw values are.
	task automatic test_update_disabled();
		sample_t s;
		drain_results();
		program_regs(DM_TOP_PLAIN, {PHYS_CHANNELS{CT_DIRECT}});
		s.update = 1'b0;
		s.ch     = '1;
		s.tank   = '1;
		s.pipe   = '1;
		send_sample(s);
		s.ch   = '0;
		s.tank = '0;
		s.pipe = '0;
		send_sample(s);
		s = random_sample();
		s.update = 1'b1;
		send_sample(s);
	endtask

	// Main-pipe-only installation: main pressure moves, concentrations and tank stay.
	task automatic test_main_only();
		raw_t pipe_edges [5] = '{raw_t'(0), raw_t'(65535), raw_t'(10000), raw_t'(9680),
			raw_t'(10319)};
		sample_t s;
		drain_results();
		program_regs(DM_MAIN_ONLY, {PHYS_CHANNELS{CT_INVERTED}});
		for (int k = 0; k < 6; k++) begin
			s = random_sample();
			s.update = (k != 5);
			s.pipe   = (k < 5) ? pipe_edges[k] : raw_t'($urandom);
			send_sample(s);
		end
	endtask

	// Random traffic in phases, each with its own register setting and idling pattern.
	// The first phases pin the extreme settings; the rest draw them at random.
	task automatic test_random_traffic();
		cfg_data_t model;
		type_set_t types;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					model = DM_PLAIN;
					types = {PHYS_CHANNELS{CT_INVERTED}};
				end
				1: begin
					model = DM_TOP_PLAIN;
					types = {PHYS_CHANNELS{CT_DIRECT}};
				end
				2: begin
					model = cfg_data_t'($urandom_range(0, 2));
					types = {PHYS_CHANNELS{CT_HOLD_ALT}};
				end
				3: begin
					model = DM_MAIN_ONLY;
					types = type_set_t'($urandom);
				end
				default: begin
					model = cfg_data_t'($urandom);
					types = type_set_t'($urandom);
				end
			endcase
			case (phase % 4)
				0: begin
					src_wait_max  = 0;
					sink_wait_max = 0;
				end
				1: begin
					src_wait_max  = MAX_WAIT;
					sink_wait_max = MAX_WAIT;
				end
				2: begin
					src_wait_max  = MAX_WAIT;
					sink_wait_max = 0;
				end
				default: begin
					src_wait_max  = 0;
					sink_wait_max = MAX_WAIT;
				end
			endcase
			drain_results();
			program_regs(model, types);
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				// Halfway through odd phases the sender holds off until the block is empty.
				if (phase % 2 == 1 && k == PHASE_SAMPLES / 2) begin
					drain_results();
					drain_pauses++;
				end
				send_sample(random_sample());
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		in_valid          = 1'b0;
		update_enable     = 1'b0;
		raw_ch0           = '0;
		raw_ch1           = '0;
		raw_ch2           = '0;
		raw_ch3           = '0;
		raw_ch4           = '0;
		raw_tank_pressure = '0;
		raw_main_pressure = '0;
		model_shadow      = DM_PLAIN;
		type_shadow       = {PHYS_CHANNELS{CT_HOLD}};
		conc_shadow       = '0;
		tank_shadow       = '0;
		pipe_shadow       = '0;
		src_wait_max      = MAX_WAIT;
		sink_wait_max     = MAX_WAIT;
		cycle_count       = 0;
		samples_sent      = 0;
		results_checked   = 0;
		mismatch_count    = 0;
		settings_count    = 0;
		drain_pauses      = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_scaling_extremes();
		test_hold_types();
		test_update_disabled();
		test_main_only();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d sample transfers over %0d register settings, %0d results checked",
			samples_sent, settings_count, results_checked);
		$display("with %0d full drains mid-stream and %0d field mismatches", drain_pauses,
			mismatch_count);
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("nitrogen_sensor_scaling_tb: done, clean");
		else
			$display("nitrogen_sensor_scaling_tb: done, errors");
		$finish;
	end

endmodule
